/* hdl/bpt_pkg.sv */
// Package for the barometer compensation pipeline: payload structs,
// calibration struct, register indexes, reset values and formula constants.
// No dependencies.
`timescale 1ns / 1ps

package bpt_pkg;

   localparam int DivW = 32;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_press;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature;
      logic [31:0]        pressure;
      logic               div_error;
   } rsp_type;

   // calibration words as the datapath sees them
   typedef struct packed {
      logic [1:0]  oss;
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
   } cal_type;

   // sideband through the temperature divider
   typedef struct packed {
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        err;
   } tside_type;

   // sideband through the pressure divider
   typedef struct packed {
      logic [31:0] b5;
      logic        big;
      logic        err;
   } pside_type;

   typedef enum logic [2:0] {
      REG_OSS   = 3'd0,
      REG_CAL_A = 3'd1,
      REG_CAL_B = 3'd2,
      REG_CAL_C = 3'd3,
      REG_CAL_D = 3'd4
   } reg_idx_type;

   localparam logic [1:0]  RstOss  = 2'd0;
   localparam logic [47:0] RstCalA = 48'h0198FFB8C7D1;
   localparam logic [47:0] RstCalB = 48'h7FE57FF55A71;
   localparam logic [31:0] RstCalC = 32'h182E0004;
   localparam logic [31:0] RstCalD = 32'hDDF90B34;

   localparam logic [31:0] K4000  = 32'd4000;
   localparam logic [31:0] K50000 = 32'd50000;
   localparam logic [31:0] K32768 = 32'd32768;
   localparam logic [31:0] K3038  = 32'd3038;
   localparam logic [31:0] K7357  = 32'd7357;
   localparam logic [31:0] K3791  = 32'd3791;

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

/* hdl/bpt_div.sv */
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage,
// with a sideband word riding along. Uses bpt_pkg.
`timescale 1ns / 1ps

module bpt_div #(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         in_num,
   input  logic [31:0]         in_den,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [31:0]         out_quot,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int N = bpt_pkg::DivW;

   logic              v_ff    [N+1];
   logic [31:0]       num_ff  [N+1];
   logic [31:0]       rem_ff  [N+1];
   logic [31:0]       den_ff  [N+1];
   logic [SIDE_W-1:0] side_ff [N+1];

   always_comb begin
      v_ff[0]    = in_valid;
      num_ff[0]  = in_num;
      rem_ff[0]  = '0;
      den_ff[0]  = in_den;
      side_ff[0] = in_side;
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [32:0] trial;
      logic [32:0] diff;
      logic        fits;

      always_comb begin
         trial = {rem_ff[k-1], num_ff[k-1][31]};
         diff  = trial - {1'b0, den_ff[k-1]};
         fits  = !diff[32];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? diff[31:0] : trial[31:0];
            num_ff[k]  <= {num_ff[k-1][30:0], fits};
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_quot  = num_ff[N];
   assign out_side  = side_ff[N];

endmodule

/* hdl/bpt_coef.sv */
// Middle of the pipeline: B5 from the temperature quotient, then B6, B3,
// B4 and B7, ending in the operands of the pressure divider. Uses bpt_pkg.
`timescale 1ns / 1ps

module bpt_coef (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  bpt_pkg::cal_type    cal,
   input  logic                in_valid,
   input  logic [31:0]         in_quot,
   input  bpt_pkg::tside_type  in_side,
   output logic                out_valid,
   output logic [31:0]         out_num,
   output logic [31:0]         out_den,
   output bpt_pkg::pside_type  out_side
);

   // stage 1
   logic        c1_v_ff, c1_err_ff;
   logic [31:0] c1_b5_ff, c1_b5_in;
   logic [18:0] c1_up_ff;
   // stage 2
   logic        c2_v_ff, c2_err_ff;
   logic [31:0] c2_b5_ff, c2_sq_ff, c2_xa_ff, c2_xc_ff;
   logic [31:0] c2_sq_in, c2_xa_in, c2_xc_in, b6;
   logic [18:0] c2_up_ff;
   // stage 3
   logic        c3_v_ff, c3_err_ff;
   logic [31:0] c3_b5_ff, c3_xa_ff, c3_xc_ff, c3_y1_ff, c3_y2_ff, c3_y1_in, c3_y2_in;
   logic [18:0] c3_up_ff;
   // stage 4
   logic        c4_v_ff, c4_err_ff;
   logic [31:0] c4_b5_ff, c4_b3_ff, c4_x3_ff, c4_b3_in, c4_x3_in, x3a;
   logic [18:0] c4_up_ff;
   // stage 5
   logic        c5_v_ff, c5_err_ff;
   logic [31:0] c5_b5_ff, c5_b4_ff, c5_b7_ff, c5_b4_in, c5_b7_in, b4_prod;
   // stage 6
   logic        c6_v_ff;
   logic [31:0] c6_num_ff, c6_den_ff;
   bpt_pkg::pside_type c6_side_ff;

   always_comb begin
      c1_b5_in = in_side.x1 + (in_side.neg ? (32'd0 - in_quot) : in_quot);

      b6       = c1_b5_ff - bpt_pkg::K4000;
      c2_sq_in = bpt_pkg::asr(b6 * b6, 5'd12);
      c2_xa_in = bpt_pkg::asr(bpt_pkg::sx16(cal.ac2) * b6, 5'd11);
      c2_xc_in = bpt_pkg::asr(bpt_pkg::sx16(cal.ac3) * b6, 5'd13);

      c3_y1_in = bpt_pkg::asr(bpt_pkg::sx16(cal.b2) * c2_sq_ff, 5'd11);
      c3_y2_in = bpt_pkg::asr(bpt_pkg::sx16(cal.b1) * c2_sq_ff, 5'd16);

      x3a      = c3_y1_ff + c3_xa_ff;
      c4_b3_in = bpt_pkg::asr((((bpt_pkg::sx16(cal.ac1) << 2) + x3a) << cal.oss) + 32'd2,
                              5'd2);
      c4_x3_in = bpt_pkg::asr(c3_xc_ff + c3_y2_ff + 32'd2, 5'd2);

      b4_prod  = {16'd0, cal.ac4} * (c4_x3_ff + bpt_pkg::K32768);
      c5_b4_in = b4_prod >> 15;
      c5_b7_in = ({13'd0, c4_up_ff} - c4_b3_ff) * (bpt_pkg::K50000 >> cal.oss);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
         c5_v_ff <= 1'b0;
         c6_v_ff <= 1'b0;
      end else if (en) begin
         c1_v_ff <= in_valid;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
         c4_v_ff <= c3_v_ff;
         c5_v_ff <= c4_v_ff;
         c6_v_ff <= c5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_b5_ff  <= c1_b5_in;
         c1_up_ff  <= in_side.up;
         c1_err_ff <= in_side.err;

         c2_b5_ff  <= c1_b5_ff;
         c2_up_ff  <= c1_up_ff;
         c2_err_ff <= c1_err_ff;
         c2_sq_ff  <= c2_sq_in;
         c2_xa_ff  <= c2_xa_in;
         c2_xc_ff  <= c2_xc_in;

         c3_b5_ff  <= c2_b5_ff;
         c3_up_ff  <= c2_up_ff;
         c3_err_ff <= c2_err_ff;
         c3_xa_ff  <= c2_xa_ff;
         c3_xc_ff  <= c2_xc_ff;
         c3_y1_ff  <= c3_y1_in;
         c3_y2_ff  <= c3_y2_in;

         c4_b5_ff  <= c3_b5_ff;
         c4_up_ff  <= c3_up_ff;
         c4_err_ff <= c3_err_ff;
         c4_b3_ff  <= c4_b3_in;
         c4_x3_ff  <= c4_x3_in;

         c5_b5_ff  <= c4_b5_ff;
         c5_err_ff <= c4_err_ff;
         c5_b4_ff  <= c5_b4_in;
         c5_b7_ff  <= c5_b7_in;

         // large B7 divides first and doubles after
         c6_num_ff      <= c5_b7_ff[31] ? c5_b7_ff : (c5_b7_ff << 1);
         c6_den_ff      <= c5_b4_ff;
         c6_side_ff.b5  <= c5_b5_ff;
         c6_side_ff.big <= c5_b7_ff[31];
         c6_side_ff.err <= c5_err_ff || (c5_b4_ff == 32'd0);
      end
   end

   assign out_valid = c6_v_ff;
   assign out_num   = c6_num_ff;
   assign out_den   = c6_den_ff;
   assign out_side  = c6_side_ff;

endmodule

/* hdl/bpt_final.sv */
// Tail of the pipeline: pressure correction polynomial, temperature
// rounding and the output register. Uses bpt_pkg.
`timescale 1ns / 1ps

module bpt_final (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         in_quot,
   input  bpt_pkg::pside_type  in_side,
   output logic                out_valid,
   output bpt_pkg::rsp_type    out_data
);

   logic        f1_v_ff, f2_v_ff, f3_v_ff, f4_v_ff;
   logic [31:0] f1_p_ff, f2_p_ff, f3_p_ff;
   logic [31:0] f2_m1_ff, f2_m2_ff, f3_m2_ff, f3_x1_ff;
   logic [31:0] f2_m1_in, f2_m2_in, f3_x1_in, ph, corr, tq;
   bpt_pkg::pside_type f1_side_ff, f2_side_ff, f3_side_ff;
   bpt_pkg::rsp_type   f4_data_ff, f4_data_in;

   always_comb begin
      ph       = f1_p_ff >> 8;
      f2_m1_in = ph * ph;
      f2_m2_in = bpt_pkg::asr(32'd0 - bpt_pkg::K7357 * f1_p_ff, 5'd16);
      f3_x1_in = bpt_pkg::asr(f2_m1_ff * bpt_pkg::K3038, 5'd16);
      corr     = bpt_pkg::asr(f3_x1_ff + f3_m2_ff + bpt_pkg::K3791, 5'd4);
      tq       = bpt_pkg::asr(f3_side_ff.b5 + 32'd8, 5'd4);
      if (f3_side_ff.err) begin
         f4_data_in = '0;
         f4_data_in.div_error = 1'b1;
      end else begin
         f4_data_in.temperature = $signed(tq[15:0]);
         f4_data_in.pressure    = f3_p_ff + corr;
         f4_data_in.div_error   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
         f4_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= in_valid;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
         f4_v_ff <= f3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_p_ff    <= in_side.big ? (in_quot << 1) : in_quot;
         f1_side_ff <= in_side;
         f2_p_ff    <= f1_p_ff;
         f2_m1_ff   <= f2_m1_in;
         f2_m2_ff   <= f2_m2_in;
         f2_side_ff <= f1_side_ff;
         f3_p_ff    <= f2_p_ff;
         f3_x1_ff   <= f3_x1_in;
         f3_m2_ff   <= f2_m2_ff;
         f3_side_ff <= f2_side_ff;
         f4_data_ff <= f4_data_in;
      end
   end

   assign out_valid = f4_v_ff;
   assign out_data  = f4_data_ff;

endmodule

/* hdl/baro_pressure_temp_compensation.sv */
// Top level of the barometer compensation pipeline: CSR bank, temperature
// front stages, two pipelined dividers and the coef/final sections.
// Uses bpt_pkg, bpt_div, bpt_coef, bpt_final.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | bpt_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_stall | bpt_pkg::rsp_type
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// One request per cycle unless a stalled response holds the pipeline. Stages: 2 front,
// 32 in the temperature divider, 6 coef, 32 in the pressure divider, 4 final.
// The divider pipelines, one quotient bit per stage, set the depth.
// Synchronous reset clears the valid bits and loads the calibration defaults.
// A stalled response freezes the whole pipeline; req_stall follows it.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bpt_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bpt_pkg::rsp_type   rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);

   logic        en;
   logic [1:0]  oss_ff;
   logic [47:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff, cal_d_ff;
   bpt_pkg::cal_type cal;

   logic        t1_v_ff, t2_v_ff;
   logic [31:0] t1_x1_ff, t1_x1_in;
   logic [18:0] t1_up_ff;
   logic [31:0] t2_num_ff, t2_den_ff, den, num;
   bpt_pkg::tside_type t2_side_ff;

   logic               d1_valid, d2_valid, c_valid, d_in_valid;
   logic [31:0]        d1_quot, d2_quot, c_num, c_den;
   bpt_pkg::tside_type d1_side;
   bpt_pkg::pside_type c_side, d2_side;
   logic [$bits(bpt_pkg::tside_type)-1:0] d1_side_raw;
   logic [$bits(bpt_pkg::pside_type)-1:0] d2_side_raw;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff   <= bpt_pkg::RstOss;
         cal_a_ff <= bpt_pkg::RstCalA;
         cal_b_ff <= bpt_pkg::RstCalB;
         cal_c_ff <= bpt_pkg::RstCalC;
         cal_d_ff <= bpt_pkg::RstCalD;
      end else if (csr_we) begin
         unique case (csr_index)
            bpt_pkg::REG_OSS:   oss_ff   <= csr_wdata[1:0];
            bpt_pkg::REG_CAL_A: cal_a_ff <= csr_wdata;
            bpt_pkg::REG_CAL_B: cal_b_ff <= csr_wdata;
            bpt_pkg::REG_CAL_C: cal_c_ff <= csr_wdata[31:0];
            bpt_pkg::REG_CAL_D: cal_d_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.oss = oss_ff;
      cal.ac1 = cal_a_ff[47:32];
      cal.ac2 = cal_a_ff[31:16];
      cal.ac3 = cal_a_ff[15:0];
      cal.ac4 = cal_b_ff[47:32];
      cal.ac5 = cal_b_ff[31:16];
      cal.ac6 = cal_b_ff[15:0];
      cal.b1  = cal_c_ff[31:16];
      cal.b2  = cal_c_ff[15:0];
      cal.mc  = cal_d_ff[31:16];
      cal.md  = cal_d_ff[15:0];
   end

   // front: X1, then the signed MC*2^11 / (X1+MD) as magnitudes
   always_comb begin
      t1_x1_in = bpt_pkg::asr(({16'd0, req_data.raw_temp} - {16'd0, cal.ac6})
                              * {16'd0, cal.ac5}, 5'd15);
      den = t1_x1_ff + bpt_pkg::sx16(cal.md);
      num = bpt_pkg::sx16(cal.mc) << 11;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= req_valid;
         t2_v_ff <= t1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_x1_ff       <= t1_x1_in;
         t1_up_ff       <= req_data.raw_press;
         t2_num_ff      <= num[31] ? (32'd0 - num) : num;
         t2_den_ff      <= den[31] ? (32'd0 - den) : den;
         t2_side_ff.x1  <= t1_x1_ff;
         t2_side_ff.up  <= t1_up_ff;
         t2_side_ff.neg <= num[31] ^ den[31];
         t2_side_ff.err <= (den == 32'd0);
      end
   end

   bpt_div #(.SIDE_W($bits(bpt_pkg::tside_type))) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t2_v_ff),
      .in_num    (t2_num_ff),
      .in_den    (t2_den_ff),
      .in_side   (t2_side_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side_raw)
   );

   assign d1_side = bpt_pkg::tside_type'(d1_side_raw);

   bpt_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal),
      .in_valid  (d1_valid),
      .in_quot   (d1_quot),
      .in_side   (d1_side),
      .out_valid (c_valid),
      .out_num   (c_num),
      .out_den   (c_den),
      .out_side  (c_side)
   );

   assign d_in_valid = c_valid;

   bpt_div #(.SIDE_W($bits(bpt_pkg::pside_type))) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_in_valid),
      .in_num    (c_num),
      .in_den    (c_den),
      .in_side   (c_side),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side_raw)
   );

   assign d2_side = bpt_pkg::pside_type'(d2_side_raw);

   bpt_final u_final (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d2_valid),
      .in_quot   (d2_quot),
      .in_side   (d2_side),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

/* hdl/bpt_checker.sv */
// Port-level checks for the barometer compensation pipeline and the bind
// that attaches them to the top level. Uses bpt_pkg.
`timescale 1ns / 1ps

module bpt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bpt_pkg::rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an error response carries zero results
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_error |->
         rsp_data.pressure == 32'd0 && rsp_data.temperature == 16'sd0)
      else $error("error response with nonzero results");

   // output back-pressure reaches the request side in the same cycle
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind baro_pressure_temp_compensation bpt_checker u_bpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* dv/tb_baro_pressure_temp_compensation.sv */
// Testbench for the barometer compensation pipeline: drives reading pairs,
// predicts temperature/pressure with its own integer model, checks in order.
// Depends on bpt_pkg and baro_pressure_temp_compensation.
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bpt_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bpt_pkg::rsp_type  rsp_data;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [47:0]       csr_wdata = '0;

   // local copy of the calibration registers
   logic [1:0]  m_oss;
   logic [47:0] m_cal_a, m_cal_b;
   logic [31:0] m_cal_c, m_cal_d;

   bpt_pkg::rsp_type expected_q[$];
   int          errors = 0;
   int          n_checked = 0;
   int          n_diverr = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   baro_pressure_temp_compensation dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sgn16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic bpt_pkg::rsp_type compensate(input bpt_pkg::req_type r);
      bpt_pkg::rsp_type o;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, den, b5, b6, b6sq, b3, b4, b7, p, ut, up;
      longint      q;
      ac1 = sgn16(m_cal_a[47:32]); ac2 = sgn16(m_cal_a[31:16]); ac3 = sgn16(m_cal_a[15:0]);
      ac4 = {16'd0, m_cal_b[47:32]}; ac5 = {16'd0, m_cal_b[31:16]};
      ac6 = {16'd0, m_cal_b[15:0]};
      b1 = sgn16(m_cal_c[31:16]); b2 = sgn16(m_cal_c[15:0]);
      mc = sgn16(m_cal_d[31:16]); md = sgn16(m_cal_d[15:0]);
      ut = {16'd0, r.raw_temp};
      up = {13'd0, r.raw_press};
      o = '0;
      o.div_error = 1'b1;
      x1 = sra((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return o;
      q = longint'($signed(mc << 11)) / longint'($signed(den));
      x2 = q[31:0];
      b5 = x1 + x2;
      b6 = b5 - 32'd4000;
      b6sq = sra(b6 * b6, 12);
      x1 = sra(b2 * b6sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra((((ac1 << 2) + x3) << m_oss) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * b6sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return o;
      b7 = (up - b3) * (32'd50000 >> m_oss);
      if (b7[31]) p = (b7 / b4) << 1;
      else p = (b7 << 1) / b4;
      x1 = (p >> 8) * (p >> 8);
      x1 = sra(x1 * 32'd3038, 16);
      x2 = sra(32'd0 - 32'd7357 * p, 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      x3 = sra(b5 + 32'd8, 4);
      o.temperature = x3[15:0];
      o.pressure = p;
      o.div_error = 1'b0;
      return o;
   endfunction

   // receiver: random stall, check each response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            bpt_pkg::rsp_type e;
            e = expected_q.pop_front();
            n_checked++;
            if (e.div_error) n_diverr++;
            if (rsp_data.temperature !== e.temperature) begin
               $display("%0t: temperature exp %0d got %0d", $time, e.temperature,
                        rsp_data.temperature);
               errors++;
            end
            if (rsp_data.pressure !== e.pressure) begin
               $display("%0t: pressure exp %0d got %0d", $time, e.pressure,
                        rsp_data.pressure);
               errors++;
            end
            if (rsp_data.div_error !== e.div_error) begin
               $display("%0t: div_error exp %0b got %0b", $time, e.div_error,
                        rsp_data.div_error);
               errors++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
      bpt_pkg::req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      r.raw_temp = ut;
      r.raw_press = up;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(compensate(r));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (90) @(negedge clock);
   endtask

   task automatic write_reg(input bpt_pkg::reg_idx_type idx, input logic [47:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         bpt_pkg::REG_OSS:   m_oss = val[1:0];
         bpt_pkg::REG_CAL_A: m_cal_a = val;
         bpt_pkg::REG_CAL_B: m_cal_b = val;
         bpt_pkg::REG_CAL_C: m_cal_c = val[31:0];
         default:            m_cal_d = val[31:0];
      endcase
   endtask

   task automatic load_defaults;
      write_reg(bpt_pkg::REG_OSS, 48'(bpt_pkg::RstOss));
      write_reg(bpt_pkg::REG_CAL_A, bpt_pkg::RstCalA);
      write_reg(bpt_pkg::REG_CAL_B, bpt_pkg::RstCalB);
      write_reg(bpt_pkg::REG_CAL_C, 48'(bpt_pkg::RstCalC));
      write_reg(bpt_pkg::REG_CAL_D, 48'(bpt_pkg::RstCalD));
   endtask

   task automatic test_extremes;
      send_reading(16'd0, 19'd0);
      send_reading(16'hFFFF, 19'h7FFFF);
      send_reading(16'd27898, 19'd23843);
      send_reading(16'hAAAA, 19'h55555);
      send_reading(16'h5555, 19'h2AAAA);
      send_reading(16'd27898, 19'h7FFFF);
      send_reading(16'd0, 19'h7FFFF);
      send_reading(16'hFFFF, 19'd0);
      drain();
   endtask

   task automatic test_oversampling;
      for (int s = 3; s >= 0; s--) begin
         write_reg(bpt_pkg::REG_OSS, 48'(s));
         send_reading(16'd27898, 19'd23843 << s);
         send_reading(16'd30000, 19'h7FFFF);
         send_reading(16'd20000, 19'd0);
         drain();
      end
   endtask

   task automatic test_div_errors;
      // temperature divisor zero: AC5=0 makes X1 zero, MD=0
      write_reg(bpt_pkg::REG_CAL_B, 48'h7FE500005A71);
      write_reg(bpt_pkg::REG_CAL_D, 48'hDDF90000);
      send_reading(16'd1234, 19'd4321);
      drain();
      write_reg(bpt_pkg::REG_CAL_D, 48'(bpt_pkg::RstCalD));
      // pressure divisor zero: AC4=0
      write_reg(bpt_pkg::REG_CAL_B, 48'h00007FF55A71);
      send_reading(16'd27898, 19'd23843);
      drain();
      // extreme calibration words
      write_reg(bpt_pkg::REG_CAL_A, 48'hFFFF_FFFF_FFFF);
      write_reg(bpt_pkg::REG_CAL_B, 48'hFFFF_FFFF_FFFF);
      write_reg(bpt_pkg::REG_CAL_C, 48'hFFFF_FFFF);
      write_reg(bpt_pkg::REG_CAL_D, 48'h8000_7FFF);
      send_reading(16'hFFFF, 19'h7FFFF);
      send_reading(16'd0, 19'd0);
      drain();
      write_reg(bpt_pkg::REG_CAL_A, 48'h8000_8000_8000);
      write_reg(bpt_pkg::REG_CAL_B, 48'd0);
      write_reg(bpt_pkg::REG_CAL_C, 48'h8000_8000);
      write_reg(bpt_pkg::REG_CAL_D, 48'h7FFF_8000);
      send_reading(16'hFFFF, 19'h7FFFF);
      send_reading(16'd0, 19'd12345);
      drain();
      load_defaults();
   endtask

   task automatic test_random(input int count, input bit rand_cal);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            drain();
            if (rand_cal) begin
               write_reg(bpt_pkg::REG_CAL_A, 48'({$urandom, $urandom}));
               write_reg(bpt_pkg::REG_CAL_B, 48'({$urandom, $urandom}));
               write_reg(bpt_pkg::REG_CAL_C, 48'($urandom));
               write_reg(bpt_pkg::REG_CAL_D, 48'($urandom));
            end else
               load_defaults();
            write_reg(bpt_pkg::REG_OSS, 48'($urandom_range(3)));
         end
         // mostly realistic readings, some fully random
         if ($urandom_range(3) != 0)
            send_reading(16'($urandom_range(33000, 22000)),
                         19'($urandom_range(120000, 10000) << m_oss));
         else
            send_reading(16'($urandom), 19'($urandom));
      end
      drain();
   endtask

   initial begin
      m_oss = bpt_pkg::RstOss; m_cal_a = bpt_pkg::RstCalA; m_cal_b = bpt_pkg::RstCalB;
      m_cal_c = bpt_pkg::RstCalC; m_cal_d = bpt_pkg::RstCalD;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_oversampling();
      test_div_errors();
      send_idle_pct = 36; stall_pct = 65;
      test_random(280, 1'b0);
      send_idle_pct = 65; stall_pct = 36;
      test_random(280, 1'b1);
      send_idle_pct = 0; stall_pct = 0;
      test_random(290, 1'b1);
      $display("checked %0d responses (%0d with divide error) over default, random",
               n_checked, n_diverr);
      $display("and extreme calibrations, all oversampling settings, idle and stall mixes");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
